>>> sv/tga_rle_pkg.sv
`default_nettype none

package tga_rle_pkg;

  localparam int unsigned CfgIndexWidth = 8;
  localparam int unsigned CfgDataWidth  = 16;

  typedef enum logic [CfgIndexWidth-1:0] {
    REG_BYTES_PER_PIXEL = 8'd0,
    REG_COMPRESSED_MODE = 8'd1,
    REG_IMAGE_WIDTH     = 8'd2,
    REG_IMAGE_HEIGHT    = 8'd3
  } cfg_reg_t;

  localparam logic [6:0] CountMask = 7'h7F;

  // Settings seen by the decode logic.
  typedef struct packed {
    logic [2:0]  bytes_per_pixel;
    logic        compressed_mode;
    logic [31:0] pixel_total;
  } cfg_t;

  // Decoder state carried from byte to byte.
  typedef struct packed {
    logic        expect_header;
    logic        run_packet;
    logic [7:0]  packet_left;
    logic [1:0]  byte_index;
    logic [31:0] color_buffer;
    logic [31:0] pixels_left;
  } dec_state_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] pixel_word;
    logic [7:0]  repeat_count;
    logic        image_last;
    logic        overrun;
  } dec_result_t;

endpackage

`default_nettype wire

>>> sv/tga_rle_pixel_decoder_top.sv
// TGA run-length pixel decoder.
//
// Body bytes enter on the input channel (in_valid, in_stall, in_byte), one
// request per byte. Pixels leave on the output channel (out_valid, out_stall)
// with pixel_word, repeat_count, image_last and overrun. Header bytes and
// the leading bytes of a pixel give no output request.
// Settings are written through the cfg channel (cfg_valid, cfg_ready,
// cfg_index, cfg_data) while no byte is in flight; cfg_ready is always high.
// Index 0 is bytes per pixel, 1 the compressed mode, 2 the width, 3 the height.
//
// A byte lands in an input register and is decoded from there, once the
// output register is free, into the output register that holds the pixel request.
// One byte per cycle is sustained while the output does not stall; the
// limit is the single decode step between the input and output registers.
// A stalled output holds its request, and the input stalls only while its
// register holds a byte that has nowhere to go.
// Reset restores the default settings (4 bytes per pixel, compressed,
// 1 x 1 image) and drops any byte or pixel in flight.
`default_nettype none

module tga_rle_pixel_decoder_top (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  cfg_valid,
  output logic                                       cfg_ready,
  input  wire logic [tga_rle_pkg::CfgIndexWidth-1:0] cfg_index,
  input  wire logic [tga_rle_pkg::CfgDataWidth-1:0]  cfg_data,
  input  wire logic                                  in_valid,
  output logic                                       in_stall,
  input  wire logic [7:0]                            in_byte,
  output logic                                       out_valid,
  input  wire logic                                  out_stall,
  output logic [31:0]                                pixel_word,
  output logic [7:0]                                 repeat_count,
  output logic                                       image_last,
  output logic                                       overrun
);

  tga_rle_pkg::cfg_t         cfg;
  tga_rle_pkg::dec_state_t   state;
  tga_rle_pkg::dec_state_t   state_next;
  tga_rle_pkg::dec_result_t  result;

  logic       in_full;
  logic [7:0] in_hold;
  logic       out_free;
  logic       advance;
  logic       accept;

  tga_rle_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  tga_rle_step u_step (
    .cfg        (cfg),
    .state      (state),
    .in_byte    (in_hold),
    .state_next (state_next),
    .result     (result)
  );

  assign out_free = !out_valid || !out_stall;
  assign advance  = in_full && out_free;
  assign in_stall = in_full && !out_free;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (accept) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_hold <= in_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state.expect_header <= 1'b1;
      state.run_packet    <= 1'b0;
      state.packet_left   <= 8'd0;
      state.byte_index    <= 2'd0;
      state.color_buffer  <= 32'd0;
      state.pixels_left   <= 32'd0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= advance && result.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && advance && result.valid) begin
      pixel_word   <= result.pixel_word;
      repeat_count <= result.repeat_count;
      image_last   <= result.image_last;
      overrun      <= result.overrun;
    end
  end

endmodule

`default_nettype wire

>>> sv/tga_rle_cfg.sv
`default_nettype none

module tga_rle_cfg (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  cfg_valid,
  output logic                                       cfg_ready,
  input  wire logic [tga_rle_pkg::CfgIndexWidth-1:0] cfg_index,
  input  wire logic [tga_rle_pkg::CfgDataWidth-1:0]  cfg_data,
  output tga_rle_pkg::cfg_t                          cfg
);

  logic [2:0]  bytes_per_pixel;
  logic        compressed_mode;
  logic [15:0] image_width;
  logic [15:0] image_height;
  logic [31:0] pixel_total;
  logic [31:0] product;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_per_pixel <= 3'd4;
      compressed_mode <= 1'b1;
      image_width     <= 16'd1;
      image_height    <= 16'd1;
    end else if (cfg_valid) begin
      case (cfg_index)
        tga_rle_pkg::REG_BYTES_PER_PIXEL: bytes_per_pixel <= cfg_data[2:0];
        tga_rle_pkg::REG_COMPRESSED_MODE: compressed_mode <= cfg_data[0];
        tga_rle_pkg::REG_IMAGE_WIDTH:     image_width     <= cfg_data[15:0];
        tga_rle_pkg::REG_IMAGE_HEIGHT:    image_height    <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  assign product = 32'(image_width) * 32'(image_height);

  // The pixel limit is registered once behind the size registers; nothing
  // holds a byte back from the decode logic while the limit catches up.
  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_total <= 32'd1;
    end else begin
      pixel_total <= (product == 32'd0) ? 32'd1 : product;
    end
  end

  assign cfg.bytes_per_pixel = bytes_per_pixel;
  assign cfg.compressed_mode = compressed_mode;
  assign cfg.pixel_total     = pixel_total;

endmodule

`default_nettype wire

>>> sv/tga_rle_step.sv
`default_nettype none

module tga_rle_step (
  input  wire tga_rle_pkg::cfg_t         cfg,
  input  wire tga_rle_pkg::dec_state_t   state,
  input  wire logic [7:0]                in_byte,
  output tga_rle_pkg::dec_state_t        state_next,
  output tga_rle_pkg::dec_result_t       result
);

  always_comb begin
    tga_rle_pkg::dec_state_t s;
    logic [2:0]  pix_bytes;
    logic [1:0]  idx_next;
    logic [31:0] merged;
    logic [31:0] rc;
    logic        ovr;
    logic [31:0] pix;

    s         = state;
    rc        = 32'd1;
    ovr       = 1'b0;
    pix       = 32'd0;
    merged    = 32'd0;
    idx_next  = 2'd0;
    result    = '0;

    if (cfg.bytes_per_pixel == 3'd0) begin
      pix_bytes = 3'd1;
    end else if (cfg.bytes_per_pixel > 3'd4) begin
      pix_bytes = 3'd4;
    end else begin
      pix_bytes = cfg.bytes_per_pixel;
    end

    // A byte with no image in progress starts a new one.
    if (s.pixels_left == 32'd0) begin
      s.pixels_left   = cfg.pixel_total;
      s.expect_header = 1'b1;
      s.run_packet    = 1'b0;
      s.packet_left   = 8'd0;
      s.byte_index    = 2'd0;
      s.color_buffer  = 32'd0;
    end

    if (cfg.compressed_mode && s.expect_header) begin
      s.packet_left   = {1'b0, in_byte[6:0] & tga_rle_pkg::CountMask} + 8'd1;
      s.run_packet    = in_byte[7];
      s.expect_header = 1'b0;
      s.byte_index    = 2'd0;
      s.color_buffer  = 32'd0;
    end else begin
      merged = s.color_buffer;
      case (s.byte_index)
        2'd0:    merged[7:0]   = merged[7:0]   | in_byte;
        2'd1:    merged[15:8]  = merged[15:8]  | in_byte;
        2'd2:    merged[23:16] = merged[23:16] | in_byte;
        default: merged[31:24] = merged[31:24] | in_byte;
      endcase
      idx_next = s.byte_index + 2'd1;
      if (idx_next != 2'd0 && {1'b0, idx_next} < pix_bytes) begin
        s.color_buffer = merged;
        s.byte_index   = idx_next;
      end else begin
        pix            = merged;
        s.byte_index   = 2'd0;
        s.color_buffer = 32'd0;
        if (cfg.compressed_mode) begin
          if (s.packet_left == 8'd0) begin
            s.packet_left = 8'd1;
          end
          if (s.run_packet) begin
            rc = 32'(s.packet_left);
            // A run longer than what is left of the image is clamped.
            if (rc > s.pixels_left) begin
              rc  = s.pixels_left;
              ovr = 1'b1;
            end
            s.packet_left = 8'd0;
          end else begin
            s.packet_left = s.packet_left - 8'd1;
            if (s.pixels_left == 32'd1 && s.packet_left != 8'd0) begin
              ovr = 1'b1;
            end
          end
          s.pixels_left = s.pixels_left - rc;
          if (s.packet_left == 8'd0) begin
            s.expect_header = 1'b1;
          end
        end else begin
          s.pixels_left = s.pixels_left - 32'd1;
        end

        if (s.pixels_left == 32'd0) begin
          s.expect_header = 1'b1;
          s.packet_left   = 8'd0;
          s.run_packet    = 1'b0;
        end

        result.valid        = 1'b1;
        result.pixel_word   = pix;
        result.repeat_count = rc[7:0];
        result.image_last   = (s.pixels_left == 32'd0);
        result.overrun      = ovr;
      end
    end

    state_next = s;
  end

endmodule

`default_nettype wire

>>> bench/tga_rle_pixel_decoder_top_tb.sv
`default_nettype none

module tga_rle_pixel_decoder_top_tb;

  localparam int unsigned RANDOM_BYTES   = 1720;
  localparam int unsigned DRAIN_CYCLES   = 4;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned MAX_PRINTED    = 20;

  typedef enum logic [0:0] {
    ENTRY_BYTE,
    ENTRY_WRITE
  } entry_kind_t;

  typedef struct {
    entry_kind_t           kind;
    logic [7:0]            data_byte;
    tga_rle_pkg::cfg_reg_t reg_sel;
    logic [15:0]           value;
  } stream_entry_t;

  typedef struct packed {
    logic [31:0] pixel_word;
    logic [7:0]  repeat_count;
    logic        image_last;
    logic        overrun;
  } pixel_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [tga_rle_pkg::CfgIndexWidth-1:0] cfg_index = '0;
  logic [tga_rle_pkg::CfgDataWidth-1:0]  cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_byte = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] pixel_word;
  logic [7:0]  repeat_count;
  logic        image_last;
  logic        overrun;

  tga_rle_pixel_decoder_top DUT (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_byte     (in_byte),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .pixel_word  (pixel_word),
    .repeat_count(repeat_count),
    .image_last  (image_last),
    .overrun     (overrun)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  stream_entry_t byte_stream[$];
  pixel_t        expected_pixels[$];

  // Settings and decoder state as the block should hold them.
  logic [2:0]  bpp_setting = 3'd4;
  logic        compressed_setting = 1'b1;
  logic [15:0] width_setting = 16'd1;
  logic [15:0] height_setting = 16'd1;
  logic        dec_expect_header = 1'b1;
  logic        dec_run_packet = 1'b0;
  logic [7:0]  dec_packet_left = '0;
  logic [1:0]  dec_byte_index = '0;
  logic [31:0] dec_color = '0;
  logic [31:0] dec_pixels_left = '0;

  // Settings as the stimulus generator plans them.
  logic [2:0]  gen_bpp = 3'd4;
  logic        gen_compressed = 1'b1;
  logic [15:0] gen_width = 16'd1;
  logic [15:0] gen_height = 16'd1;
  int unsigned gen_left = 0;
  int unsigned bytes_queued = 0;

  int unsigned error_count = 0;
  int unsigned bytes_sent = 0;
  int unsigned writes_done = 0;
  int unsigned pixels_checked = 0;
  int unsigned images_done = 0;
  int unsigned overruns_seen = 0;
  int unsigned in_max = 16;
  int unsigned out_max = 16;
  int unsigned in_wait = 0;
  int unsigned out_wait = 0;
  int unsigned quiet_cycles = 0;
  int unsigned idle_cycles = 0;

  function automatic void apply_setting(
      input logic [tga_rle_pkg::CfgIndexWidth-1:0] sel,
      input logic [tga_rle_pkg::CfgDataWidth-1:0] data);
    case (sel)
      tga_rle_pkg::REG_BYTES_PER_PIXEL: bpp_setting = data[2:0];
      tga_rle_pkg::REG_COMPRESSED_MODE: compressed_setting = data[0];
      tga_rle_pkg::REG_IMAGE_WIDTH:     width_setting = data;
      tga_rle_pkg::REG_IMAGE_HEIGHT:    height_setting = data;
      default: ;
    endcase
  endfunction

  function automatic void decode_byte(input logic [7:0] b);
    logic [31:0] total;
    logic [31:0] count;
    logic [31:0] pix;
    logic [2:0]  need;
    logic        ovr;
    pixel_t      res;
    count = 32'd1;
    ovr = 1'b0;
    if (dec_pixels_left == 0) begin
      total = 32'(width_setting) * 32'(height_setting);
      dec_pixels_left = (total == 0) ? 32'd1 : total;
      dec_expect_header = 1'b1;
      dec_run_packet = 1'b0;
      dec_packet_left = '0;
      dec_byte_index = '0;
      dec_color = '0;
    end
    if (compressed_setting && dec_expect_header) begin
      dec_packet_left = {1'b0, b[6:0]} + 8'd1;
      dec_run_packet = b[7];
      dec_expect_header = 1'b0;
      dec_byte_index = '0;
      dec_color = '0;
      return;
    end
    dec_color = dec_color | (32'(b) << (8 * dec_byte_index));
    dec_byte_index = dec_byte_index + 2'd1;
    need = (bpp_setting == 0) ? 3'd1 : (bpp_setting > 4) ? 3'd4 : bpp_setting;
    if (dec_byte_index != 0 && dec_byte_index < need) return;
    pix = dec_color;
    dec_byte_index = '0;
    dec_color = '0;
    if (compressed_setting) begin
      if (dec_packet_left == 0) dec_packet_left = 8'd1;
      if (dec_run_packet) begin
        count = 32'(dec_packet_left);
        if (count > dec_pixels_left) begin
          count = dec_pixels_left;
          ovr = 1'b1;
        end
        dec_packet_left = '0;
      end else begin
        dec_packet_left = dec_packet_left - 8'd1;
        if (dec_pixels_left == 1 && dec_packet_left != 0) ovr = 1'b1;
      end
      dec_pixels_left = dec_pixels_left - count;
      if (dec_packet_left == 0) dec_expect_header = 1'b1;
    end else begin
      dec_pixels_left = dec_pixels_left - 32'd1;
    end
    if (dec_pixels_left == 0) begin
      dec_expect_header = 1'b1;
      dec_packet_left = '0;
      dec_run_packet = 1'b0;
    end
    res.pixel_word = pix;
    res.repeat_count = count[7:0];
    res.image_last = (dec_pixels_left == 0);
    res.overrun = ovr;
    expected_pixels.push_back(res);
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (error_count < MAX_PRINTED)
      $display("mismatch on pixel %0d: %s got 0x%0h, want 0x%0h",
               pixels_checked, what, got, want);
    error_count++;
  endtask

  task automatic queue_byte(input logic [7:0] b);
    stream_entry_t e;
    e.kind = ENTRY_BYTE;
    e.data_byte = b;
    e.reg_sel = tga_rle_pkg::REG_BYTES_PER_PIXEL;
    e.value = '0;
    byte_stream.push_back(e);
    bytes_queued++;
  endtask

  task automatic queue_write(input tga_rle_pkg::cfg_reg_t sel, input logic [15:0] val);
    stream_entry_t e;
    e.kind = ENTRY_WRITE;
    e.data_byte = '0;
    e.reg_sel = sel;
    e.value = val;
    byte_stream.push_back(e);
    case (sel)
      tga_rle_pkg::REG_BYTES_PER_PIXEL: gen_bpp = val[2:0];
      tga_rle_pkg::REG_COMPRESSED_MODE: gen_compressed = val[0];
      tga_rle_pkg::REG_IMAGE_WIDTH:     gen_width = val;
      tga_rle_pkg::REG_IMAGE_HEIGHT:    gen_height = val;
      default: ;
    endcase
  endtask

  task automatic queue_pixel();
    int unsigned n;
    n = (gen_bpp == 0) ? 1 : (gen_bpp > 4) ? 4 : gen_bpp;
    repeat (n) queue_byte(8'($urandom_range(0, 255)));
  endtask

  // Mostly well-formed packets that fit the image, some that run past its end,
  // and a little noise.
  task automatic queue_chunk();
    int unsigned pick;
    int unsigned count;
    int unsigned room;
    int unsigned n;
    int unsigned total;
    logic        run;
    if (gen_left == 0) begin
      total = 32'(gen_width) * 32'(gen_height);
      gen_left = (total == 0) ? 1 : total;
    end
    pick = $urandom_range(0, 99);
    room = (gen_left < 128) ? gen_left : 128;
    if (pick < 8) begin
      repeat ($urandom_range(1, 3)) queue_byte(8'($urandom_range(0, 255)));
    end else if (gen_compressed) begin
      run = 1'($urandom_range(0, 1));
      if (pick < 22) count = $urandom_range(1, 128);
      else if (pick < 32) count = room;
      else count = $urandom_range(1, room);
      queue_byte({run, 7'(count - 1)});
      n = (count < gen_left) ? count : gen_left;
      if (run) begin
        queue_pixel();
      end else begin
        repeat (n) queue_pixel();
      end
      gen_left -= n;
    end else begin
      n = $urandom_range(1, (gen_left < 8) ? gen_left : 8);
      repeat (n) queue_pixel();
      gen_left -= n;
    end
  endtask

  // Driver: feeds bytes and register writes from the pending stream.
  always @(posedge clk) begin
    logic          in_take;
    logic          cfg_take;
    logic          hold_in;
    logic          hold_cfg;
    logic          send_byte;
    logic          send_cfg;
    stream_entry_t head;
    if (rst) begin
      in_valid <= 1'b0;
      cfg_valid <= 1'b0;
    end else begin
      in_take = in_valid && !in_stall;
      cfg_take = cfg_valid && cfg_ready;
      send_byte = 1'b0;
      send_cfg = 1'b0;
      if (in_take) begin
        decode_byte(in_byte);
        bytes_sent++;
        quiet_cycles = 0;
        if (bytes_sent % 128 == 0) begin
          case ($urandom_range(0, 2))
            0: in_max = 0;
            1: in_max = 3;
            default: in_max = 16;
          endcase
        end
        in_wait = $urandom_range(0, in_max);
      end else if (quiet_cycles < WATCHDOG_LIMIT) begin
        quiet_cycles++;
      end
      if (cfg_take) begin
        apply_setting(cfg_index, cfg_data);
        writes_done++;
      end
      hold_in = in_valid && !in_take;
      hold_cfg = cfg_valid && !cfg_take;
      if (!hold_in && !hold_cfg) begin
        if (in_wait > 0) begin
          in_wait--;
        end else if (byte_stream.size() != 0) begin
          if (byte_stream[0].kind == ENTRY_BYTE) begin
            head = byte_stream.pop_front();
            send_byte = 1'b1;
          end else if (expected_pixels.size() == 0 && quiet_cycles >= DRAIN_CYCLES) begin
            // A byte that completes no pixel may still be inside the block.
            head = byte_stream.pop_front();
            send_cfg = 1'b1;
          end
        end
      end
      in_valid <= hold_in || send_byte;
      if (send_byte) in_byte <= head.data_byte;
      cfg_valid <= hold_cfg || send_cfg;
      if (send_cfg) begin
        cfg_index <= head.reg_sel;
        cfg_data <= head.value;
      end
    end
  end

  // Monitor: checks each pixel request against the oldest expected pixel.
  always @(posedge clk) begin
    pixel_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_pixels.size() == 0) begin
          report_mismatch("pixel with none expected, pixel_word", pixel_word, '0);
        end else begin
          want = expected_pixels.pop_front();
          if (pixel_word !== want.pixel_word)
            report_mismatch("pixel_word", pixel_word, want.pixel_word);
          if (repeat_count !== want.repeat_count)
            report_mismatch("repeat_count", 32'(repeat_count), 32'(want.repeat_count));
          if (image_last !== want.image_last)
            report_mismatch("image_last", 32'(image_last), 32'(want.image_last));
          if (overrun !== want.overrun)
            report_mismatch("overrun", 32'(overrun), 32'(want.overrun));
        end
        pixels_checked++;
        if (image_last === 1'b1) images_done++;
        if (overrun === 1'b1) overruns_seen++;
        if (pixels_checked % 64 == 0) begin
          case ($urandom_range(0, 2))
            0: out_max = 0;
            1: out_max = 2;
            default: out_max = 16;
          endcase
        end
        out_wait = $urandom_range(0, out_max);
      end
      if (out_wait > 0) begin
        out_wait--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no request accepted for %0d cycles", idle_cycles);
      $display("** tga_rle_pixel_decoder_top: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int unsigned phase_end;
    int unsigned v;

    // Default settings: a 128-pixel run into a one-pixel image.
    queue_byte(8'hFF);
    queue_byte(8'hFF);
    queue_byte(8'h00);
    queue_byte(8'hAA);
    queue_byte(8'h55);
    // Padded three-byte pixels, raw packet cut short by the image end.
    queue_write(tga_rle_pkg::REG_BYTES_PER_PIXEL, 16'd3);
    queue_write(tga_rle_pkg::REG_IMAGE_WIDTH, 16'd2);
    queue_write(tga_rle_pkg::REG_IMAGE_HEIGHT, 16'd1);
    queue_byte(8'h7F);
    queue_byte(8'h01);
    queue_byte(8'h80);
    queue_byte(8'hFE);
    queue_byte(8'h7F);
    queue_byte(8'h00);
    queue_byte(8'hFF);
    // Out-of-range pixel sizes and zero image sizes, uncompressed.
    queue_write(tga_rle_pkg::REG_BYTES_PER_PIXEL, 16'd0);
    queue_write(tga_rle_pkg::REG_COMPRESSED_MODE, 16'd0);
    queue_write(tga_rle_pkg::REG_IMAGE_WIDTH, 16'd0);
    queue_byte(8'h5A);
    queue_write(tga_rle_pkg::REG_BYTES_PER_PIXEL, 16'd7);
    queue_write(tga_rle_pkg::REG_IMAGE_HEIGHT, 16'd0);
    queue_byte(8'h12);
    queue_byte(8'h34);
    queue_byte(8'h56);
    queue_byte(8'h78);
    // Two-byte pixels, then a pixel size cut and a mode switch mid-packet.
    queue_write(tga_rle_pkg::REG_BYTES_PER_PIXEL, 16'd2);
    queue_write(tga_rle_pkg::REG_COMPRESSED_MODE, 16'd1);
    queue_write(tga_rle_pkg::REG_IMAGE_WIDTH, 16'd4);
    queue_write(tga_rle_pkg::REG_IMAGE_HEIGHT, 16'd1);
    queue_byte(8'h81);
    queue_byte(8'hA5);
    queue_byte(8'h5A);
    queue_byte(8'h01);
    queue_byte(8'hC3);
    queue_write(tga_rle_pkg::REG_BYTES_PER_PIXEL, 16'd1);
    queue_byte(8'h3C);
    queue_write(tga_rle_pkg::REG_COMPRESSED_MODE, 16'd0);
    queue_byte(8'h80);

    while (bytes_queued < RANDOM_BYTES) begin
      if ($urandom_range(0, 3) != 0) begin
        if ($urandom_range(0, 9) == 0) begin
          v = $urandom_range(0, 3);
          queue_write(tga_rle_pkg::REG_BYTES_PER_PIXEL, (v == 0) ? 16'd0 : 16'(v + 4));
        end else begin
          queue_write(tga_rle_pkg::REG_BYTES_PER_PIXEL, 16'($urandom_range(1, 4)));
        end
      end
      if ($urandom_range(0, 2) != 0)
        queue_write(tga_rle_pkg::REG_COMPRESSED_MODE, 16'($urandom_range(0, 1)));
      if ($urandom_range(0, 1) != 0) begin
        v = $urandom_range(0, 19);
        queue_write(tga_rle_pkg::REG_IMAGE_WIDTH,
                    (v == 0) ? 16'd0 : (v < 6) ? 16'd1 : 16'($urandom_range(1, 12)));
      end
      if ($urandom_range(0, 1) != 0) begin
        v = $urandom_range(0, 19);
        queue_write(tga_rle_pkg::REG_IMAGE_HEIGHT,
                    (v == 0) ? 16'd0 : (v < 6) ? 16'd1 : 16'($urandom_range(1, 10)));
      end
      phase_end = bytes_queued + $urandom_range(30, 120);
      while (bytes_queued < phase_end) queue_chunk();
      // Sometimes leave a pixel or a packet unfinished across the next writes.
      if ($urandom_range(0, 4) == 0) queue_byte(8'($urandom_range(0, 255)));
    end

    // Largest image last, since it cannot complete within the run.
    queue_write(tga_rle_pkg::REG_BYTES_PER_PIXEL, 16'd4);
    queue_write(tga_rle_pkg::REG_COMPRESSED_MODE, 16'd1);
    queue_write(tga_rle_pkg::REG_IMAGE_WIDTH, 16'hFFFF);
    queue_write(tga_rle_pkg::REG_IMAGE_HEIGHT, 16'hFFFF);
    phase_end = bytes_queued + 40;
    while (bytes_queued < phase_end) queue_chunk();

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    while (byte_stream.size() != 0 || in_valid || cfg_valid || expected_pixels.size() != 0)
      @(negedge clk);
    repeat (4 * DRAIN_CYCLES) @(negedge clk);
    if (expected_pixels.size() != 0)
      report_mismatch("expected pixels never arrived, count", expected_pixels.size(), 0);

    $display("Sent %0d body bytes and %0d register writes; checked %0d pixels.",
             bytes_sent, writes_done, pixels_checked);
    $display("Completed %0d images, %0d pixels flagged as overrun, %0d mismatches.",
             images_done, overruns_seen, error_count);
    if (error_count == 0) begin
      $display("** tga_rle_pixel_decoder_top: PASSED **");
    end else begin
      $display("** tga_rle_pixel_decoder_top: FAILED **");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> sim.f
sv/tga_rle_pkg.sv
sv/tga_rle_cfg.sv
sv/tga_rle_step.sv
sv/tga_rle_pixel_decoder_top.sv
bench/tga_rle_pixel_decoder_top_tb.sv
